>>> rtl/core/zzs_pkg.sv
package zzs_pkg;

  localparam int MAX_SIZE = 64;
  localparam int COORD_W  = $clog2(MAX_SIZE);
  localparam int SIZE_W   = 7;
  localparam int SEQ_W    = 13;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic REG_MATRIX_SIZE = 1'b0;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

  typedef struct packed {
    logic [SIZE_W-1:0] n;
    logic [SEQ_W-1:0]  total;
    logic              clear;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [SEQ_W-1:0]   seq_value;
    logic               last;
  } res_t;

endpackage

>>> rtl/core/zzs_if.sv
interface zzs_in_if;
  logic valid;
  logic ready;
  logic start_req;

  modport source (output valid, output start_req, input ready);
  modport sink (input valid, input start_req, output ready);
endinterface

interface zzs_out_if;
  logic                        valid;
  logic                        ready;
  logic [zzs_pkg::COORD_W-1:0] row;
  logic [zzs_pkg::COORD_W-1:0] col;
  logic [zzs_pkg::SEQ_W-1:0]   seq_value;
  logic                        last;

  modport source (output valid, output row, output col, output seq_value, output last,
                  input ready);
  modport sink (input valid, input row, input col, input seq_value, input last,
                output ready);
endinterface

>>> rtl/core/zzs_cfg.sv
module zzs_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [zzs_pkg::ADDR_W-1:0]  paddr,
  input  logic [zzs_pkg::DATA_W-1:0]  pwdata,
  output logic [zzs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output zzs_pkg::cfg_t               cfg
);

  logic [zzs_pkg::SIZE_W-1:0]   size_r;
  logic [zzs_pkg::SIZE_W-1:0]   n_r;
  logic [zzs_pkg::SEQ_W-1:0]    total_r;
  logic [zzs_pkg::SIZE_W-1:0]   size_nxt;
  logic [zzs_pkg::SIZE_W-1:0]   n_nxt;
  logic [2*zzs_pkg::SIZE_W-1:0] sq;
  logic                         wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == zzs_pkg::REG_MATRIX_SIZE);

  always_comb begin
    size_nxt = pwdata[zzs_pkg::SIZE_W-1:0];
    if (size_nxt == '0) begin
      n_nxt = zzs_pkg::SIZE_W'(1);
    end else if (size_nxt > zzs_pkg::SIZE_W'(zzs_pkg::MAX_SIZE)) begin
      n_nxt = zzs_pkg::SIZE_W'(zzs_pkg::MAX_SIZE);
    end else begin
      n_nxt = size_nxt;
    end
    sq = n_nxt * n_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= zzs_pkg::SIZE_RESET;
      n_r     <= zzs_pkg::SIZE_RESET;
      total_r <= zzs_pkg::SEQ_W'(zzs_pkg::SIZE_RESET * zzs_pkg::SIZE_RESET);
    end else begin
      if (wr_en) begin
        size_r  <= size_nxt;
        n_r     <= n_nxt;
        total_r <= sq[zzs_pkg::SEQ_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == zzs_pkg::REG_MATRIX_SIZE) begin
      prdata = zzs_pkg::DATA_W'(size_r);
    end
  end

  assign cfg.n     = n_r;
  assign cfg.total = total_r;
  assign cfg.clear = wr_en;

endmodule

>>> rtl/core/zzs_step.sv
module zzs_step (
  input  logic          clk,
  input  logic          rst_n,
  input  zzs_pkg::cfg_t cfg,
  input  logic          fire,
  input  logic          start_req,
  output zzs_pkg::res_t res
);

  logic [zzs_pkg::COORD_W-1:0] row_r, row_nxt;
  logic [zzs_pkg::COORD_W-1:0] col_r, col_nxt;
  logic [zzs_pkg::SEQ_W-1:0]   cnt_r, cnt_nxt;
  logic [zzs_pkg::COORD_W-1:0] nm1;
  logic                        restart;
  logic                        odd_diag;

  always_comb begin
    nm1      = zzs_pkg::COORD_W'(cfg.n - zzs_pkg::SIZE_W'(1));
    odd_diag = nm1[0] ^ row_r[0] ^ col_r[0];
    restart  = start_req || (cnt_r == '0) || (cnt_r >= cfg.total)
               || ({1'b0, row_r} >= cfg.n) || ({1'b0, col_r} >= cfg.n);
    row_nxt  = row_r;
    col_nxt  = col_r;
    cnt_nxt  = cnt_r + zzs_pkg::SEQ_W'(1);
    if (restart) begin
      row_nxt = nm1;
      col_nxt = '0;
      cnt_nxt = zzs_pkg::SEQ_W'(1);
    end else if (!odd_diag) begin
      if (row_r != '0 && col_r != '0) begin
        row_nxt = row_r - 1'b1;
        col_nxt = col_r - 1'b1;
      end else if (row_r == '0) begin
        col_nxt = col_r + 1'b1;
      end else begin
        row_nxt = row_r - 1'b1;
      end
    end else begin
      if (row_r < nm1 && col_r < nm1) begin
        row_nxt = row_r + 1'b1;
        col_nxt = col_r + 1'b1;
      end else if (col_r == nm1) begin
        row_nxt = row_r - 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      cnt_r <= '0;
    end else if (cfg.clear) begin
      cnt_r <= '0;
    end else if (fire) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign res.row       = row_nxt;
  assign res.col       = col_nxt;
  assign res.seq_value = cnt_nxt;
  assign res.last      = (cnt_nxt == cfg.total);

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg.clear |-> cnt_r <= cfg.total)
    else $error("scan count beyond matrix area");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0 && !cfg.clear) |-> ({1'b0, row_r} < cfg.n && {1'b0, col_r} < cfg.n))
    else $error("scan position outside matrix");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && start_req && !cfg.clear) |=> (cnt_r == zzs_pkg::SEQ_W'(1) && col_r == '0))
    else $error("restart did not return to first cell");
`endif

endmodule

>>> rtl/core/zzs_skid.sv
module zzs_skid (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  zzs_pkg::res_t push_data,
  output logic          can_push,
  zzs_out_if.source     out_if
);

  logic          out_valid_r;
  zzs_pkg::res_t out_data_r;
  logic          skid_valid_r;
  zzs_pkg::res_t skid_data_r;
  logic          out_free;

  assign out_free = !out_valid_r || out_if.ready;
  assign can_push = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.row       = out_data_r.row;
  assign out_if.col       = out_data_r.col;
  assign out_if.seq_value = out_data_r.seq_value;
  assign out_if.last      = out_data_r.last;

`ifndef ASSERT_OFF
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a transaction ahead of the output stage");
`endif

endmodule

>>> rtl/core/zigzag_scan_order_generator_core.sv
// Zigzag scan order generator: each accepted input transaction produces one
// cell of the anti-diagonal zigzag order of an n by n matrix (n from the
// matrix_size register, 0 read as 1, above 64 read as 64), beginning at the
// bottom-left cell, with its row, column, position from 1 and a last flag on
// cell n*n. One transaction is taken every clock cycle while the skid entry is
// empty; the result goes to the output register of a two-entry buffer, or to
// its skid register while the output stalls. The next-cell logic reads the held
// position and count, cfg and start_req. A register write restarts the scan.
module zigzag_scan_order_generator_core (
  input  logic                        clk,
  input  logic                        rst_n,
  zzs_in_if.sink                      in_if,
  zzs_out_if.source                   out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [zzs_pkg::ADDR_W-1:0]  paddr,
  input  logic [zzs_pkg::DATA_W-1:0]  pwdata,
  output logic [zzs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  zzs_pkg::cfg_t cfg;
  zzs_pkg::res_t res;
  logic          can_push;
  logic          fire;

  assign in_if.ready = can_push;
  assign fire        = in_if.valid && can_push;

  zzs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  zzs_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .fire      (fire),
    .start_req (in_if.start_req),
    .res       (res)
  );

  zzs_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .push_data (res),
    .can_push  (can_push),
    .out_if    (out_if)
  );

endmodule
